/* rtl/core/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad entry to DAC code block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int WORD_W     = 16;
  localparam int KEY_W      = 4;
  localparam int LOCKOUT_W  = 16;
  localparam int NIBBLE_W   = 4;
  localparam int ENTRY_W    = 11;
  localparam int CODE_W     = 12;
  localparam int COUNT_W    = 2;
  localparam int PROD_W     = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Keys taken into one entry (1 to 4)
  localparam int DIGITS_PER_ENTRY = 3;

  localparam int COLUMNS = 3;
  localparam int ROWS    = 4;

  localparam int SCALE_FACTOR = 4096 / 330;
  localparam int DEC_BASE     = 10;

  localparam logic [ENTRY_W-1:0]   ENTRY_MAX     = 11'd2047;
  localparam logic [CODE_W-1:0]    CODE_MAX      = 12'd4095;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd1000;
  localparam logic [NIBBLE_W-1:0]  NIBBLE_RESET  = 4'd3;

  localparam logic [KEY_W-1:0] KEY_BOTTOM_LEFT  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_BOTTOM_MID   = 4'd0;
  localparam logic [KEY_W-1:0] KEY_BOTTOM_RIGHT = 4'd11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SCANS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_CONTROL   = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENTRY,
    ST_WORD,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_DECIMAL,
    ALU_SCALE
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [ENTRY_W-1:0]  operand;
    logic [KEY_W-1:0]    addend;
  } alu_req_t;

  typedef struct packed {
    logic [LOCKOUT_W-1:0] lockout_scans;
    logic [NIBBLE_W-1:0]  dac_control_nibble;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/kpd_in_if.sv */
// ----------------------------------------------------------------------------
// kpd_in_if
// Input channel carrying one keypad matrix sample per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kpd_in_if;
  logic                           valid;
  logic                           ready;
  logic [kpd_pkg::SAMPLE_W-1:0]   matrix_sample;

  modport source (output valid, output matrix_sample, input ready);
  modport sink   (input valid, input matrix_sample, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpd_out_if.sv */
// ----------------------------------------------------------------------------
// kpd_out_if
// Result channel carrying the DAC word and key status of one scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [kpd_pkg::WORD_W-1:0]   dac_word;
  logic                         key_valid;
  logic [kpd_pkg::KEY_W-1:0]    key_code;
  logic                         word_updated;

  modport source (output valid, output dac_word, output key_valid, output key_code,
                  output word_updated, input ready);
  modport sink   (input valid, input dac_word, input key_valid, input key_code,
                  input word_updated, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpd_cfg_if.sv */
// ----------------------------------------------------------------------------
// kpd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kpd_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [kpd_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/kpd_alu.sv */
// ----------------------------------------------------------------------------
// kpd_alu
// Shared multiply-add-saturate unit: decimal digit append and DAC scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpd_alu (
  input  kpd_pkg::alu_req_t              req,
  output logic [kpd_pkg::CODE_W-1:0]     result
);

  logic [kpd_pkg::KEY_W-1:0]   factor;
  logic [kpd_pkg::PROD_W-1:0]  prod;
  logic [kpd_pkg::PROD_W-1:0]  limit;

  always_comb begin
    case (req.op)
      kpd_pkg::ALU_DECIMAL: begin
        factor = kpd_pkg::KEY_W'(kpd_pkg::DEC_BASE);
        limit  = kpd_pkg::PROD_W'(kpd_pkg::ENTRY_MAX);
      end
      kpd_pkg::ALU_SCALE: begin
        factor = kpd_pkg::KEY_W'(kpd_pkg::SCALE_FACTOR);
        limit  = kpd_pkg::PROD_W'(kpd_pkg::CODE_MAX);
      end
      default: begin
        factor = '0;
        limit  = '0;
      end
    endcase
    prod = kpd_pkg::PROD_W'(req.operand) * kpd_pkg::PROD_W'(factor)
         + kpd_pkg::PROD_W'(req.addend);
    // Both limits fit in the result width, so saturation also does the masking.
    if (prod >= limit) begin
      result = limit[kpd_pkg::CODE_W-1:0];
    end else begin
      result = prod[kpd_pkg::CODE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kpd_ctrl.sv */
// ----------------------------------------------------------------------------
// kpd_ctrl
// Scan sequencer: lockout, key search, entry build-up and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  kpd_in_if.sink                        in_ch,
  kpd_out_if.source                     out_ch,
  input  kpd_pkg::cfg_t                 cfg,
  output kpd_pkg::alu_req_t             alu_req,
  input  logic [kpd_pkg::CODE_W-1:0]    alu_result
);

  kpd_pkg::state_t state_r, state_nxt;

  logic [kpd_pkg::SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic [kpd_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic                           key_valid_r, key_valid_nxt;
  logic                           updated_r, updated_nxt;
  logic [kpd_pkg::COUNT_W-1:0]    digit_count_r, digit_count_nxt;
  logic [kpd_pkg::ENTRY_W-1:0]    entry_r, entry_nxt;
  logic [kpd_pkg::WORD_W-1:0]     word_r, word_nxt;
  logic [kpd_pkg::LOCKOUT_W-1:0]  lockout_r, lockout_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [kpd_pkg::WORD_W-1:0]     out_word_r, out_word_nxt;
  logic                           out_key_valid_r, out_key_valid_nxt;
  logic [kpd_pkg::KEY_W-1:0]      out_key_code_r, out_key_code_nxt;
  logic                           out_updated_r, out_updated_nxt;

  logic                           found;
  logic [kpd_pkg::KEY_W-1:0]      found_key;
  logic [kpd_pkg::COUNT_W:0]      count_inc;

  // Lowest column with a pressed row wins; within it the highest row wins.
  function automatic logic [kpd_pkg::KEY_W:0] find_key(
    input logic [kpd_pkg::SAMPLE_W-1:0] sample
  );
    logic [kpd_pkg::ROWS-1:0]   rows;
    logic [kpd_pkg::KEY_W-1:0]  key;
    logic                       hit;
    logic [1:0]                 row;
    hit = 1'b0;
    key = '0;
    for (int c = kpd_pkg::COLUMNS - 1; c >= 0; c--) begin
      rows = sample[c*kpd_pkg::ROWS +: kpd_pkg::ROWS];
      if (rows != '0) begin
        hit = 1'b1;
        if (rows[3]) row = 2'd3;
        else if (rows[2]) row = 2'd2;
        else if (rows[1]) row = 2'd1;
        else row = 2'd0;
        if (row != 2'd3) begin
          key = kpd_pkg::KEY_W'(row) * 4'd3 + kpd_pkg::KEY_W'(c) + 4'd1;
        end else if (c == 0) begin
          key = kpd_pkg::KEY_BOTTOM_LEFT;
        end else if (c == 1) begin
          key = kpd_pkg::KEY_BOTTOM_MID;
        end else begin
          key = kpd_pkg::KEY_BOTTOM_RIGHT;
        end
      end
    end
    return {hit, key};
  endfunction

  assign {found, found_key} = find_key(sample_r);
  assign count_inc = {1'b0, digit_count_r} + 3'd1;

  assign in_ch.ready         = (state_r == kpd_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.dac_word     = out_word_r;
  assign out_ch.key_valid    = out_key_valid_r;
  assign out_ch.key_code     = out_key_code_r;
  assign out_ch.word_updated = out_updated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= kpd_pkg::ST_IDLE;
      digit_count_r <= '0;
      entry_r       <= '0;
      word_r        <= '0;
      lockout_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      digit_count_r <= digit_count_nxt;
      entry_r       <= entry_nxt;
      word_r        <= word_nxt;
      lockout_r     <= lockout_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r        <= sample_nxt;
    key_r           <= key_nxt;
    key_valid_r     <= key_valid_nxt;
    updated_r       <= updated_nxt;
    out_word_r      <= out_word_nxt;
    out_key_valid_r <= out_key_valid_nxt;
    out_key_code_r  <= out_key_code_nxt;
    out_updated_r   <= out_updated_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    sample_nxt        = sample_r;
    key_nxt           = key_r;
    key_valid_nxt     = key_valid_r;
    updated_nxt       = updated_r;
    digit_count_nxt   = digit_count_r;
    entry_nxt         = entry_r;
    word_nxt          = word_r;
    lockout_nxt       = lockout_r;
    out_valid_nxt     = out_valid_r;
    out_word_nxt      = out_word_r;
    out_key_valid_nxt = out_key_valid_r;
    out_key_code_nxt  = out_key_code_r;
    out_updated_nxt   = out_updated_r;

    alu_req.op      = kpd_pkg::ALU_DECIMAL;
    alu_req.operand = entry_r;
    alu_req.addend  = key_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      kpd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt = in_ch.matrix_sample;
          state_nxt  = kpd_pkg::ST_SCAN;
        end
      end
      kpd_pkg::ST_SCAN: begin
        key_valid_nxt = 1'b0;
        key_nxt       = '0;
        updated_nxt   = 1'b0;
        if (lockout_r != '0) begin
          lockout_nxt = lockout_r - 16'd1;
          state_nxt   = kpd_pkg::ST_DONE;
        end else if (found) begin
          key_valid_nxt = 1'b1;
          key_nxt       = found_key;
          lockout_nxt   = cfg.lockout_scans;
          state_nxt     = kpd_pkg::ST_ENTRY;
        end else begin
          state_nxt = kpd_pkg::ST_DONE;
        end
      end
      kpd_pkg::ST_ENTRY: begin
        alu_req.op      = kpd_pkg::ALU_DECIMAL;
        alu_req.operand = entry_r;
        alu_req.addend  = key_r;
        entry_nxt       = alu_result[kpd_pkg::ENTRY_W-1:0];
        if (count_inc >= 3'(kpd_pkg::DIGITS_PER_ENTRY)) begin
          state_nxt = kpd_pkg::ST_WORD;
        end else begin
          digit_count_nxt = count_inc[kpd_pkg::COUNT_W-1:0];
          state_nxt       = kpd_pkg::ST_DONE;
        end
      end
      kpd_pkg::ST_WORD: begin
        alu_req.op      = kpd_pkg::ALU_SCALE;
        alu_req.operand = entry_r;
        alu_req.addend  = '0;
        word_nxt        = {cfg.dac_control_nibble, alu_result};
        updated_nxt     = 1'b1;
        digit_count_nxt = '0;
        entry_nxt       = '0;
        state_nxt       = kpd_pkg::ST_DONE;
      end
      kpd_pkg::ST_DONE: begin
        // The result register frees up in the same cycle it is taken.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          out_word_nxt      = word_r;
          out_key_valid_nxt = key_valid_r;
          out_key_code_nxt  = key_r;
          out_updated_nxt   = updated_r;
          state_nxt         = kpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/keypad_entry_to_dac_code.sv */
// ----------------------------------------------------------------------------
// keypad_entry_to_dac_code
// Scans a 4x3 keypad sample per transaction and forms a DAC word per entry.
// An ignored or empty scan goes from the scan step straight to done; a digit
// key passes through the entry step, and the key that completes an entry also
// through the word step, both using the shared multiply-add unit, before the
// result is registered in done. A new scan is taken only in idle, and a result
// still waiting on out_ch.ready holds the sequencer in done as long as it waits.
// Reset (rst_n, synchronous, active low) clears the entry, word and lockout
// and loads lockout_scans = 1000 and dac_control_nibble = 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_entry_to_dac_code (
  input  logic        clk,
  input  logic        rst_n,
  kpd_in_if.sink      in_ch,
  kpd_out_if.source   out_ch,
  kpd_cfg_if.sink     cfg_ch
);

  kpd_pkg::cfg_t                 cfg_r, cfg_nxt;
  kpd_pkg::alu_req_t             alu_req;
  logic [kpd_pkg::CODE_W-1:0]    alu_result;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        kpd_pkg::CFG_LOCKOUT_SCANS: begin
          cfg_nxt.lockout_scans = cfg_ch.wdata[kpd_pkg::LOCKOUT_W-1:0];
        end
        kpd_pkg::CFG_DAC_CONTROL: begin
          cfg_nxt.dac_control_nibble = cfg_ch.wdata[kpd_pkg::NIBBLE_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_scans      <= kpd_pkg::LOCKOUT_RESET;
      cfg_r.dac_control_nibble <= kpd_pkg::NIBBLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg_r),
    .alu_req    (alu_req),
    .alu_result (alu_result)
  );

  kpd_alu u_alu (
    .req    (alu_req),
    .result (alu_result)
  );

`ifndef SYNTHESIS
  // The sequencer is not ready again in the cycle after it takes a scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after a transaction");

  // A completed entry always comes with the key that completed it.
  a_update_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.word_updated) |-> out_ch.key_valid)
    else $error("word updated without an accepted key");

  // No key reported means a zero key code.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.key_valid) |-> (out_ch.key_code == '0))
    else $error("nonzero key code without a key");

  // A new word always carries the configured control nibble.
  a_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.word_updated)
      |-> (out_ch.dac_word[kpd_pkg::WORD_W-1 -: kpd_pkg::NIBBLE_W]
           == cfg_r.dac_control_nibble))
    else $error("DAC word control nibble mismatch");
`endif

endmodule

`default_nettype wire

/* verif/keypad_entry_to_dac_code_tb.sv */
// ----------------------------------------------------------------------------
// keypad_entry_to_dac_code_tb
// Self-checking testbench for the keypad entry to DAC code block. Keypad
// samples are driven through the input channel with random gaps. A scoreboard
// class predicts the scan result of every accepted sample from its own copy of
// the entry state and the registers, and compares each result transaction
// field by field. Register settings change between phases while the block is
// idle. A directed sequence comes first, then random scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_entry_to_dac_code_tb;
  import kpd_pkg::*;

  localparam int                   STALL_PCT  = 15;
  localparam int                   IDLE_LIMIT = 2000;
  localparam int                   DRAIN_WAIT = 10;
  // No register lives at this index, so a write must leave the setup alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  typedef struct packed {
    logic [WORD_W-1:0] dac_word;
    logic              key_valid;
    logic [KEY_W-1:0]  key_code;
    logic              word_updated;
  } scan_result_t;

  class kpd_scoreboard;
    scan_result_t         expected_q[$];
    logic [LOCKOUT_W-1:0] lockout_scans;
    logic [NIBBLE_W-1:0]  control_nibble;
    int unsigned          digit_count;
    int unsigned          entry_value;
    logic [WORD_W-1:0]    dac_word;
    logic [LOCKOUT_W-1:0] lockout_left;
    int unsigned          errors;

    function new();
      lockout_scans  = LOCKOUT_RESET;
      control_nibble = NIBBLE_RESET;
      digit_count    = 0;
      entry_value    = 0;
      dac_word       = '0;
      lockout_left   = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_LOCKOUT_SCANS) begin
        lockout_scans = data[LOCKOUT_W-1:0];
      end else if (idx == CFG_DAC_CONTROL) begin
        control_nibble = data[NIBBLE_W-1:0];
      end
    endfunction

    // Predicts one scan; returns one when the sample was not under lockout.
    function bit note_scan(logic [SAMPLE_W-1:0] sample);
      scan_result_t   res;
      logic [ROWS-1:0] rows;
      bit             found;
      int unsigned    col;
      int unsigned    row;
      int unsigned    key;
      int unsigned    scaled;
      logic [CODE_W-1:0] code;
      bit             open_scan;

      res       = '0;
      found     = 0;
      key       = 0;
      open_scan = (lockout_left == 0);
      if (!open_scan) begin
        lockout_left = lockout_left - 1'b1;
      end else begin
        for (col = 0; col < COLUMNS; col++) begin
          rows = sample[col*ROWS +: ROWS];
          if (!found && rows != '0) begin
            found = 1;
            row = rows[3] ? 3 : rows[2] ? 2 : rows[1] ? 1 : 0;
            if (row <= 2) begin
              key = row * 3 + col + 1;
            end else begin
              case (col)
                0: key = KEY_BOTTOM_LEFT;
                1: key = KEY_BOTTOM_MID;
                default: key = KEY_BOTTOM_RIGHT;
              endcase
            end
          end
        end
        if (found) begin
          res.key_valid = 1'b1;
          res.key_code  = key[KEY_W-1:0];
          entry_value   = entry_value * DEC_BASE + key;
          if (entry_value > ENTRY_MAX) entry_value = ENTRY_MAX;
          digit_count++;
          lockout_left = lockout_scans;
          if (digit_count >= DIGITS_PER_ENTRY) begin
            scaled = entry_value * SCALE_FACTOR;
            code = (scaled >= CODE_MAX) ? CODE_MAX : scaled[CODE_W-1:0];
            dac_word = {control_nibble, code};
            res.word_updated = 1'b1;
            digit_count = 0;
            entry_value = 0;
          end
        end
      end
      res.dac_word = dac_word;
      expected_q.push_back(res);
      return open_scan;
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t exp_res;

      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.dac_word !== exp_res.dac_word) begin
        $display("%0t: dac_word mismatch, expected %h, actual %h",
                 $time, exp_res.dac_word, got.dac_word);
        errors++;
      end
      if (got.key_valid !== exp_res.key_valid) begin
        $display("%0t: key_valid mismatch, expected %b, actual %b",
                 $time, exp_res.key_valid, got.key_valid);
        errors++;
      end
      if (got.key_code !== exp_res.key_code) begin
        $display("%0t: key_code mismatch, expected %0d, actual %0d",
                 $time, exp_res.key_code, got.key_code);
        errors++;
      end
      if (got.word_updated !== exp_res.word_updated) begin
        $display("%0t: word_updated mismatch, expected %b, actual %b",
                 $time, exp_res.word_updated, got.word_updated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady_flow;
  int   idle_cycles = 0;

  kpd_in_if  in_bus();
  kpd_out_if out_bus();
  kpd_cfg_if cfg_bus();

  kpd_scoreboard sb;

  keypad_entry_to_dac_code i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] random_scan();
    int pick;
    logic [SAMPLE_W-1:0] s;

    pick = $urandom_range(99);
    if (pick < 60) begin
      s = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
    end else if (pick < 72) begin
      s = '0;
    end else if (pick < 87) begin
      s = SAMPLE_W'($urandom_range(4095));
    end else begin
      s = (SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1)) |
          (SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1));
    end
    return s;
  endfunction

  // Valid is left high after the transaction so the next scan can follow
  // without a bubble; a gap lowers it first.
  task automatic send_scan(input logic [SAMPLE_W-1:0] sample, output bit open_scan);
    while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.matrix_sample <= sample;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    open_scan = sb.note_scan(sample);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Every scan gives a result, so an empty scoreboard means the block is idle.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [LOCKOUT_W-1:0] lockout, input logic [NIBBLE_W-1:0] ctrl);
    drain();
    cfg_write(CFG_LOCKOUT_SCANS, lockout);
    cfg_write(CFG_DAC_CONTROL, {12'($urandom_range(4095)), ctrl});
    cfg_bus.valid <= 1'b0;
  endtask

  // Runs random scans until the given number has been looked at outside lockout.
  task automatic run_phase(input int open_wanted, input int steady_first);
    int open_count;
    bit open_scan;

    open_count = 0;
    while (open_count < open_wanted) begin
      steady_flow = (open_count < steady_first);
      send_scan(random_scan(), open_scan);
      if (open_scan) open_count++;
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result({out_bus.dac_word, out_bus.key_valid, out_bus.key_code,
                       out_bus.word_updated});
    end
    out_bus.ready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] directed[$];
    bit open_scan;

    sb = new();
    steady_flow          = 1'b0;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.matrix_sample = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = '0;
    cfg_bus.wdata        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans with no lockout and the reset control nibble: empty scan,
    // clamp boundary (341 fits, 342 clamps), all zeros, several keys at once
    // (lowest column, highest row), every key and both bottom corners.
    cfg_write(CFG_LOCKOUT_SCANS, '0);
    cfg_bus.valid <= 1'b0;
    directed = '{12'h000,
                 12'h100, 12'h002, 12'h001,
                 12'h100, 12'h002, 12'h010,
                 12'h080, 12'h080, 12'h080,
                 12'hFFF, 12'hF00, 12'h0F0,
                 12'h800, 12'h800, 12'h800,
                 12'h020, 12'h200, 12'h004,
                 12'h040, 12'h400, 12'h008};
    foreach (directed[i]) send_scan(directed[i], open_scan);

    // A one-scan lockout: the scan after each accepted key is skipped, held keys repeat.
    set_config(16'd1, 4'hF);
    run_phase(300, 0);

    // No lockout and a zero nibble, starting with both sides streaming.
    set_config(16'd0, 4'h0);
    run_phase(300, 100);

    drain();
    cfg_write(CFG_UNUSED, 16'($urandom_range(65535)));
    set_config(LOCKOUT_W'($urandom_range(5, 2)), NIBBLE_W'($urandom_range(15)));
    run_phase(250, 0);

    // Longest lockout: after the first key no further key is accepted in this run.
    set_config(16'hFFFF, 4'h9);
    repeat (20) send_scan(random_scan(), open_scan);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
